// ===== sv/slex_pkg.sv =====
`timescale 1ns / 1ps
// slex_pkg: shared types, codes, character constants and the word table
// for the script lexer; no dependencies

package slex_pkg;

    localparam int POSITION_BITS_DEF = 16;

    localparam int CHAR_W    = 8;
    localparam int KIND_W    = 3;
    localparam int CODE_W    = 5;
    localparam int RES_W     = 16;
    localparam int WLEN_W    = 6;
    localparam int KEY_BYTES = 18;
    localparam int KEY_BITS  = KEY_BYTES * CHAR_W;
    localparam int IDX_W     = $clog2(KEY_BYTES);
    localparam int TABLE_SIZE = 18;

    localparam logic [WLEN_W-1:0] WLEN_MAX = '1;

    typedef logic [CHAR_W-1:0] char_t;
    typedef logic [KIND_W-1:0] kind_t;
    typedef logic [CODE_W-1:0] code_t;

    // token kinds
    localparam kind_t KIND_KEYWORD  = 3'd0;
    localparam kind_t KIND_OPERATOR = 3'd1;
    localparam kind_t KIND_IDENT    = 3'd2;
    localparam kind_t KIND_CONST    = 3'd3;
    localparam kind_t KIND_DELIM    = 3'd4;

    // keyword codes
    localparam code_t KW_IF         = 5'd0;
    localparam code_t KW_ELSE       = 5'd1;
    localparam code_t KW_WHILE      = 5'd2;
    localparam code_t KW_FOR        = 5'd3;
    localparam code_t KW_DO         = 5'd4;
    localparam code_t KW_UNTIL      = 5'd5;
    localparam code_t KW_REPEAT     = 5'd6;
    localparam code_t KW_JUMP       = 5'd7;
    localparam code_t KW_SELECT     = 5'd8;
    localparam code_t KW_SET        = 5'd9;
    localparam code_t KW_CONTEXTUAL = 5'd10;

    // operator codes
    localparam code_t OP_ASSIGN = 5'd0;
    localparam code_t OP_DOT    = 5'd1;
    localparam code_t OP_PLUS   = 5'd2;
    localparam code_t OP_MINUS  = 5'd3;
    localparam code_t OP_MUL    = 5'd4;
    localparam code_t OP_DIV    = 5'd5;
    localparam code_t OP_LT     = 5'd6;
    localparam code_t OP_GT     = 5'd8;
    localparam code_t OP_POW    = 5'd10;
    localparam code_t OP_NOT    = 5'd11;
    localparam code_t OP_SAMEAS = 5'd13;
    localparam code_t OP_MOD    = 5'd14;
    localparam code_t OP_CREATE = 5'd16;
    localparam code_t OP_IS     = 5'd17;

    // delimiter codes
    localparam code_t DL_LBRACK = 5'd0;
    localparam code_t DL_RBRACK = 5'd1;
    localparam code_t DL_LPAREN = 5'd2;
    localparam code_t DL_RPAREN = 5'd3;
    localparam code_t DL_LBRACE = 5'd4;
    localparam code_t DL_RBRACE = 5'd5;
    localparam code_t DL_COMMA  = 5'd6;
    localparam code_t DL_END    = 5'd7;
    localparam code_t DL_SEMI   = 5'd8;

    // constant codes, identifier code
    localparam code_t CONST_NUMBER = 5'd0;
    localparam code_t CONST_STRING = 5'd1;
    localparam code_t IDENT_CODE   = 5'd0;

    // characters
    localparam char_t CH_NUL        = 8'h00;
    localparam char_t CH_UNDERSCORE = "_";
    localparam char_t CH_QUOTE      = "\"";
    localparam char_t CH_BACKSLASH  = "\\";
    localparam char_t CH_DOT        = ".";

    typedef struct packed {
        logic [KEY_BITS-1:0] text;
        logic [WLEN_W-1:0]   len;
        kind_t               kind;
        code_t               code;
    } word_entry_t;

    // text is right aligned: first character in the highest used byte
    localparam word_entry_t WORD_TABLE [TABLE_SIZE] = '{
        '{KEY_BITS'("if"),       6'd2,  KIND_KEYWORD,  KW_IF},
        '{KEY_BITS'("else"),     6'd4,  KIND_KEYWORD,  KW_ELSE},
        '{KEY_BITS'("while"),    6'd5,  KIND_KEYWORD,  KW_WHILE},
        '{KEY_BITS'("for"),      6'd3,  KIND_KEYWORD,  KW_FOR},
        '{KEY_BITS'("do"),       6'd2,  KIND_KEYWORD,  KW_DO},
        '{KEY_BITS'("until"),    6'd5,  KIND_KEYWORD,  KW_UNTIL},
        '{KEY_BITS'("repeat"),   6'd6,  KIND_KEYWORD,  KW_REPEAT},
        '{KEY_BITS'("jump"),     6'd4,  KIND_KEYWORD,  KW_JUMP},
        '{KEY_BITS'("select"),   6'd6,  KIND_KEYWORD,  KW_SELECT},
        '{KEY_BITS'("set"),      6'd3,  KIND_KEYWORD,  KW_SET},
        '{KEY_BITS'({"contextual", "_command"}), 6'd18, KIND_KEYWORD, KW_CONTEXTUAL},
        '{KEY_BITS'("pow"),      6'd3,  KIND_OPERATOR, OP_POW},
        '{KEY_BITS'("not"),      6'd3,  KIND_OPERATOR, OP_NOT},
        '{KEY_BITS'("sameas"),   6'd6,  KIND_OPERATOR, OP_SAMEAS},
        '{KEY_BITS'("mod"),      6'd3,  KIND_OPERATOR, OP_MOD},
        '{KEY_BITS'("CREATE"),   6'd6,  KIND_OPERATOR, OP_CREATE},
        '{KEY_BITS'("is"),       6'd2,  KIND_OPERATOR, OP_IS},
        '{KEY_BITS'("end"),      6'd3,  KIND_DELIM,    DL_END}
    };

    typedef struct packed {
        kind_t             kind;
        code_t             code;
        logic [RES_W-1:0]  start;
        logic [RES_W-1:0]  len;
    } token_t;

    function automatic logic is_alpha(input char_t c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic is_digit(input char_t c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_word_char(input char_t c);
        return is_alpha(c) || is_digit(c) || (c == CH_UNDERSCORE);
    endfunction

    function automatic logic is_op_char(input char_t c);
        logic hit;
        case (c) inside
            "=", ".", "+", "-", "*", "/", "<", ">": hit = 1'b1;
            default:                                hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic code_t op_code(input char_t c);
        code_t code;
        case (c)
            "=":     code = OP_ASSIGN;
            ".":     code = OP_DOT;
            "+":     code = OP_PLUS;
            "-":     code = OP_MINUS;
            "*":     code = OP_MUL;
            "/":     code = OP_DIV;
            "<":     code = OP_LT;
            ">":     code = OP_GT;
            default: code = OP_ASSIGN;
        endcase
        return code;
    endfunction

    function automatic logic is_delim_char(input char_t c);
        logic hit;
        case (c) inside
            "[", "]", "(", ")", "{", "}", ",", ";": hit = 1'b1;
            default:                                hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic code_t delim_code(input char_t c);
        code_t code;
        case (c)
            "[":     code = DL_LBRACK;
            "]":     code = DL_RBRACK;
            "(":     code = DL_LPAREN;
            ")":     code = DL_RPAREN;
            "{":     code = DL_LBRACE;
            "}":     code = DL_RBRACE;
            ",":     code = DL_COMMA;
            ";":     code = DL_SEMI;
            default: code = DL_LBRACK;
        endcase
        return code;
    endfunction

endpackage

// ===== sv/script_lexer.sv =====
`timescale 1ns / 1ps
// script_lexer: top level, input beat register, result register and checks
// uses slex_pkg and slex_engine
//
// usage
// - input channel: one text byte per beat on ch, with in_valid / in_ready;
//   a zero byte ends the text, drops any open token and returns offsets to 0
// - output channel: one token per beat on tok_kind, token_code, start_res
//   and length, with out_valid / out_ready
// - a token is closed by the byte after it (a closing quote closes a string
//   itself), so a token leaves one beat after the byte that ends it
// - a byte taken into the input register is lexed once the result register is
//   free or draining; the token it closes is loaded into the result register
// - throughput: one byte per cycle while the result register is free or draining,
//   set by the engine's per-byte update (mode, offsets, word buffer, parallel compare)
// - the input register takes a new byte while a token waits in the result
//   register; a byte is held in the input register only while a token is
//   still waiting and out_ready is low, and in_ready falls then
// - reset: both registers empty, lexer in seek mode at offset 0
// - offsets saturate at 2^POSITION_BITS-1; start_res and length give the low
//   16 bits

module script_lexer
    import slex_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [CHAR_W-1:0]   ch,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [KIND_W-1:0]   tok_kind,
    output logic [CODE_W-1:0]   token_code,
    output logic [RES_W-1:0]    start_res,
    output logic [RES_W-1:0]    length
);

    // input beat register
    logic   in_v_reg;
    char_t  ch_reg;

    // result register
    logic   out_v_reg;
    token_t tok_reg;

    logic   fire;
    logic   emit;
    token_t tok;

    // lex the held byte when the result register is free or draining
    assign fire     = in_v_reg && (!out_v_reg || out_ready);
    assign in_ready = !in_v_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            in_v_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            ch_reg <= ch;
        end
    end

    slex_engine #(
        .POSITION_BITS (POSITION_BITS)
    ) u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .ch    (ch_reg),
        .emit  (emit),
        .token (tok)
    );

    // result register: load on a new token, clear once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (fire && emit)
        begin
            out_v_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && emit)
        begin
            tok_reg <= tok;
        end
    end

    assign out_valid  = out_v_reg;
    assign tok_kind   = tok_reg.kind;
    assign token_code = tok_reg.code;
    assign start_res  = tok_reg.start;
    assign length     = tok_reg.len;

    // a held byte that cannot be lexed stays put
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_v_reg && !fire |=> in_v_reg && $stable(ch_reg))
        else $error("input beat register lost or changed a stalled byte");

    // end of text never produces a token
    a_eot_silent: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (ch_reg == CH_NUL) |-> !emit)
        else $error("zero byte produced a token");

    // only defined kinds leave the block
    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg |-> (tok_reg.kind <= KIND_DELIM))
        else $error("token kind out of range");

endmodule

// ===== sv/slex_classify.sv =====
`timescale 1ns / 1ps
// slex_classify: exact parallel compare of the buffered word against the
// keyword, word operator and statement end table; uses slex_pkg

module slex_classify
    import slex_pkg::*;
(
    input  char_t              wbuf [KEY_BYTES],
    input  logic [WLEN_W-1:0]  wlen,
    output kind_t              kind,
    output code_t              code
);

    logic [TABLE_SIZE-1:0] hit;

    // one comparator per table entry, bytes past the entry length ignored
    always_comb
    begin
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            hit[i] = (wlen == WORD_TABLE[i].len);
            for (int j = 0; j < KEY_BYTES; j++)
            begin
                if (j < int'(WORD_TABLE[i].len))
                begin
                    if (wbuf[j] !=
                        WORD_TABLE[i].text[(int'(WORD_TABLE[i].len) - 1 - j) * CHAR_W +: CHAR_W])
                    begin
                        hit[i] = 1'b0;
                    end
                end
            end
        end
    end

    // table order gives priority, first entry wins
    always_comb
    begin
        kind = KIND_IDENT;
        code = IDENT_CODE;
        for (int i = TABLE_SIZE - 1; i >= 0; i--)
        begin
            if (hit[i])
            begin
                kind = WORD_TABLE[i].kind;
                code = WORD_TABLE[i].code;
            end
        end
    end

endmodule

// ===== sv/slex_engine.sv =====
`timescale 1ns / 1ps
// slex_engine: lexer state, word buffer and one-byte next-state logic;
// uses slex_pkg and slex_classify

module slex_engine
    import slex_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   fire,
    input  char_t  ch,
    output logic   emit,
    output token_t token
);

    localparam int MODE_W = 3;
    localparam logic [MODE_W-1:0] MODE_SEEK  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_WORD  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_OPER  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DELIM = 3'd3;
    localparam logic [MODE_W-1:0] MODE_NUM   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_STR   = 3'd5;

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    logic [MODE_W-1:0]        mode_reg, mode_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [POSITION_BITS-1:0] tstart_reg, tstart_next;
    char_t                    prev_reg, prev_next;
    logic [WLEN_W-1:0]        wlen_reg, wlen_next;
    char_t                    wbuf_reg [KEY_BYTES];

    logic                     buf_we;
    logic [IDX_W-1:0]         buf_idx;
    logic                     examine;
    kind_t                    word_kind;
    code_t                    word_code;

    slex_classify u_classify (
        .wbuf (wbuf_reg),
        .wlen (wlen_reg),
        .kind (word_kind),
        .code (word_code)
    );

    always_comb
    begin
        mode_next   = mode_reg;
        pos_next    = pos_reg;
        tstart_next = tstart_reg;
        prev_next   = prev_reg;
        wlen_next   = wlen_reg;
        buf_we      = 1'b0;
        buf_idx     = '0;
        examine     = 1'b1;
        emit        = 1'b0;
        token.kind  = KIND_IDENT;
        token.code  = IDENT_CODE;
        token.start = RES_W'(tstart_reg);
        token.len   = RES_W'(pos_reg - tstart_reg);

        if (ch == CH_NUL)
        begin
            // end of text: drop the open token, back to reset values
            mode_next   = MODE_SEEK;
            pos_next    = '0;
            tstart_next = '0;
            prev_next   = CH_NUL;
            wlen_next   = '0;
        end
        else
        begin
            unique case (mode_reg)
                MODE_WORD:
                begin
                    if (is_word_char(ch))
                    begin
                        if (wlen_reg < WLEN_W'(KEY_BYTES))
                        begin
                            buf_we  = 1'b1;
                            buf_idx = wlen_reg[IDX_W-1:0];
                        end
                        if (wlen_reg != WLEN_MAX)
                        begin
                            wlen_next = wlen_reg + 1'b1;
                        end
                        examine = 1'b0;
                    end
                    else
                    begin
                        emit       = 1'b1;
                        token.kind = word_kind;
                        token.code = word_code;
                        mode_next  = MODE_SEEK;
                    end
                end
                MODE_OPER:
                begin
                    if (is_op_char(ch))
                    begin
                        examine = 1'b0;
                    end
                    else
                    begin
                        emit       = 1'b1;
                        token.kind = KIND_OPERATOR;
                        token.code = op_code(wbuf_reg[0]);
                        mode_next  = MODE_SEEK;
                    end
                end
                MODE_DELIM:
                begin
                    emit       = 1'b1;
                    token.kind = KIND_DELIM;
                    token.code = delim_code(wbuf_reg[0]);
                    mode_next  = MODE_SEEK;
                end
                MODE_NUM:
                begin
                    if (is_digit(ch) || (ch == CH_DOT))
                    begin
                        examine = 1'b0;
                    end
                    else
                    begin
                        emit       = 1'b1;
                        token.kind = KIND_CONST;
                        token.code = CONST_NUMBER;
                        mode_next  = MODE_SEEK;
                    end
                end
                MODE_STR:
                begin
                    if ((ch == CH_QUOTE) && (prev_reg != CH_BACKSLASH))
                    begin
                        emit       = 1'b1;
                        token.kind = KIND_CONST;
                        token.code = CONST_STRING;
                        mode_next  = MODE_SEEK;
                    end
                    examine = 1'b0;
                end
                default:
                begin
                    mode_next = MODE_SEEK;
                end
            endcase

            if (examine)
            begin
                tstart_next = pos_reg;
                if (is_alpha(ch) || (ch == CH_UNDERSCORE))
                begin
                    mode_next = MODE_WORD;
                    buf_we    = 1'b1;
                    buf_idx   = '0;
                    wlen_next = WLEN_W'(1);
                end
                else if (is_op_char(ch))
                begin
                    mode_next = MODE_OPER;
                    buf_we    = 1'b1;
                    buf_idx   = '0;
                end
                else if (is_delim_char(ch))
                begin
                    mode_next = MODE_DELIM;
                    buf_we    = 1'b1;
                    buf_idx   = '0;
                end
                else if (ch == CH_QUOTE)
                begin
                    // string text starts after the opening quote
                    mode_next = MODE_STR;
                    if (pos_reg != POS_MAX)
                    begin
                        tstart_next = pos_reg + 1'b1;
                    end
                end
                else if (is_digit(ch))
                begin
                    mode_next = MODE_NUM;
                end
            end

            if (pos_reg != POS_MAX)
            begin
                pos_next = pos_reg + 1'b1;
            end
            prev_next = ch;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_SEEK;
            pos_reg    <= '0;
            tstart_reg <= '0;
            prev_reg   <= CH_NUL;
            wlen_reg   <= '0;
        end
        else if (fire)
        begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            tstart_reg <= tstart_next;
            prev_reg   <= prev_next;
            wlen_reg   <= wlen_next;
        end
    end

    // word buffer, payload only
    always_ff @(posedge clk)
    begin
        if (fire && buf_we)
        begin
            wbuf_reg[buf_idx] <= ch;
        end
    end

endmodule
